### hw/rtl/npcs_pkg.sv
`default_nettype none

package npcs_pkg;

	// palette geometry
	localparam int PALETTE_ENTRIES = 256;
	localparam int ENTRY_W         = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [ENTRY_W-1:0] LAST_ENTRY = ENTRY_W'(PALETTE_ENTRIES - 1);

	// field widths
	localparam int IDX_W   = 8;
	localparam int COLOR_W = 24;
	localparam int CH_W    = 8;
	localparam int NUM_CH  = 3;
	localparam int SQ_W    = 2 * CH_W;
	localparam int COST_W  = 4 * CH_W;
	localparam int DIST_W  = 34;

	// largest distance: three channels at 255^4
	localparam logic [DIST_W-1:0] MAX_DIST = 34'd12684751875;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		MET_ABS  = 2'd0,
		MET_SQR  = 2'd1,
		MET_CUBE = 2'd2,
		MET_QUAD = 2'd3
	} metric_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	// one distance from the shared unit
	typedef struct packed {
		logic                valid;
		logic [ENTRY_W-1:0]  index;
		logic [DIST_W-1:0]   gap;
	} dist_res_t;

endpackage

`default_nettype wire

### hw/rtl/nearest_palette_color_search_core.sv
`default_nettype none

// Nearest palette color search. Holds a PALETTE_ENTRIES-deep RGB palette
// (256 by default) and answers "which entry is closest to this color?"
// under the metric held in the config register: sum of |d|, d^2, |d|^3
// or d^4 over the three channels (reset: squares). An input item with
// tuser = 0 writes tdata's color into entry entry_index and returns
// nothing; entries at or beyond the palette size are dropped.
// An item with tuser = 1 is a query: the palette is streamed through one
// shared distance pipeline, one entry per cycle, through the single
// palette read port; the result (lowest index with the smallest
// distance, and that exact 34-bit distance) is loaded into the output
// register once the last entry leaves the pipeline. s_tready is low
// during the scan. A finished result sits in an output register while
// the next item is taken. Every entry must be written before the first
// query; the palette has no reset. Change the metric only while idle.
module nearest_palette_color_search_core (
	input  wire         clk,
	input  wire         arst_n,
	// input items
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // [7:0] entry_index, [31:8] color
	input  wire  [0:0]  s_tuser,   // [0] action
	// result items
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,   // [7:0] nearest_index, [41:8] best_distance, rest zero
	// metric register
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_wdata
);
	import npcs_pkg::*;

	state_t state_q, state_d;

	metric_t             metric_q;
	logic [COLOR_W-1:0]  query_q;
	logic [ENTRY_W-1:0]  cnt_q;
	logic [ENTRY_W-1:0]  best_idx_q;
	logic [DIST_W-1:0]   best_dist_q;

	logic                m_tvalid_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic [DIST_W-1:0]   out_dist_q;

	// unpacked input fields
	action_t             in_action;
	logic [IDX_W-1:0]    in_index;
	logic [COLOR_W-1:0]  in_color;
	logic                in_acc;

	// sequencer outputs
	logic                issue;
	logic                ram_we;
	logic                load_out;
	logic                out_free;

	logic [COLOR_W-1:0]  ram_rdata;
	dist_res_t           dres;
	logic                last_done;
	logic                take_best;

	assign in_action = action_t'(s_tuser[0]);
	assign in_index  = s_tdata[7:0];
	assign in_color  = s_tdata[31:8];
	assign in_acc    = s_tvalid && s_tready;

	assign out_free  = !m_tvalid_q || m_tready;
	assign last_done = dres.valid && (dres.index == LAST_ENTRY);
	// entry 0 seeds the best; later entries win only when strictly closer
	assign take_best = dres.valid && ((dres.index == '0) || (dres.gap < best_dist_q));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && in_action == ACT_QUERY) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == LAST_ENTRY) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (last_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		issue    = 1'b0;
		ram_we   = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				ram_we   = in_acc && (in_action == ACT_WRITE) &&
				           ({1'b0, in_index} < (IDX_W+1)'(PALETTE_ENTRIES));
			end
			ST_SCAN:   issue    = 1'b1;
			ST_DRAIN:  ;
			ST_RESULT: load_out = out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			metric_q   <= MET_SQR;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				metric_q <= metric_t'(cfg_wdata);
			end
			if (issue) begin
				cnt_q <= (cnt_q == LAST_ENTRY) ? '0 : cnt_q + 1'b1;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			query_q <= in_color;
		end
		if (take_best) begin
			best_idx_q  <= dres.index;
			best_dist_q <= dres.gap;
		end
		if (load_out) begin
			out_idx_q  <= IDX_W'(best_idx_q);
			out_dist_q <= best_dist_q;
		end
	end

	npcs_palette_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_index[ENTRY_W-1:0]),
		.wdata (in_color),
		.re    (issue),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	npcs_dist_unit u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.issue_idx (cnt_q),
		.rdata     (ram_rdata),
		.query     (query_q),
		.metric    (metric_q),
		.res       (dres)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, out_dist_q, out_idx_q};

	// no new item is admitted while a query is in flight (scan, drain or result)
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_DRAIN || state_q == ST_RESULT) |-> !s_tready)
		else $error("input taken while a query is in flight");

	// an accepted query starts the scan at entry 0
	a_query_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_action == ACT_QUERY) |=> (state_q == ST_SCAN && cnt_q == '0))
		else $error("query did not start a scan from entry 0");

	// distance pipeline is empty whenever the sequencer is idle
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !dres.valid)
		else $error("distance result outside a scan");

	// a result is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(m_tdata) && m_tvalid))
		else $error("pending result changed");

	// reported distance stays within the metric's range
	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_dist_q <= MAX_DIST))
		else $error("distance out of range");

endmodule

`default_nettype wire

### hw/rtl/npcs_palette_ram.sv
`default_nettype none

module npcs_palette_ram (
	input  wire                                clk,
	input  wire                                we,
	input  wire  [npcs_pkg::ENTRY_W-1:0]       waddr,
	input  wire  [npcs_pkg::COLOR_W-1:0]       wdata,
	input  wire                                re,
	input  wire  [npcs_pkg::ENTRY_W-1:0]       raddr,
	output logic [npcs_pkg::COLOR_W-1:0]       rdata
);
	import npcs_pkg::*;

	logic [COLOR_W-1:0] mem [PALETTE_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/npcs_dist_unit.sv
`default_nettype none

// Shared distance pipeline: one palette entry per cycle.
// s0 ram read, s1 abs diff, s2 square, s3 power/select, s4 channel sum.
module npcs_dist_unit (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                issue,
	input  wire  [npcs_pkg::ENTRY_W-1:0]       issue_idx,
	input  wire  [npcs_pkg::COLOR_W-1:0]       rdata,
	input  wire  [npcs_pkg::COLOR_W-1:0]       query,
	input  npcs_pkg::metric_t                  metric,
	output npcs_pkg::dist_res_t                res
);
	import npcs_pkg::*;

	logic                v_s0, v_s1, v_s2, v_s3, v_s4;
	logic [ENTRY_W-1:0]  idx_s0, idx_s1, idx_s2, idx_s3, idx_s4;
	logic [CH_W-1:0]     d_s1  [NUM_CH];
	logic [CH_W-1:0]     d_s2  [NUM_CH];
	logic [SQ_W-1:0]     sq_s2 [NUM_CH];
	logic [COST_W-1:0]   cost_s3 [NUM_CH];
	logic [DIST_W-1:0]   sum_s4;

	logic [CH_W-1:0]     diff [NUM_CH];
	logic [SQ_W-1:0]     opnd [NUM_CH];
	logic [COST_W-1:0]   prod [NUM_CH];
	logic [COST_W-1:0]   cost [NUM_CH];

	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			logic [CH_W-1:0] a, b;
			a = query[k*CH_W +: CH_W];
			b = rdata[k*CH_W +: CH_W];
			diff[k] = (a > b) ? (a - b) : (b - a);
		end
	end

	// one multiplier per lane: sq*d for cubes, sq*sq for fourth powers
	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			opnd[k] = (metric == MET_QUAD) ? sq_s2[k] : {{(SQ_W-CH_W){1'b0}}, d_s2[k]};
			prod[k] = {{(COST_W-SQ_W){1'b0}}, sq_s2[k]} * {{(COST_W-SQ_W){1'b0}}, opnd[k]};
			unique case (metric)
				MET_ABS:  cost[k] = {{(COST_W-CH_W){1'b0}}, d_s2[k]};
				MET_SQR:  cost[k] = {{(COST_W-SQ_W){1'b0}}, sq_s2[k]};
				default:  cost[k] = prod[k];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s0 <= issue;
			v_s1 <= v_s0;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		idx_s0 <= issue_idx;
		idx_s1 <= idx_s0;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		for (int k = 0; k < NUM_CH; k++) begin
			d_s1[k]    <= diff[k];
			d_s2[k]    <= d_s1[k];
			sq_s2[k]   <= {{CH_W{1'b0}}, d_s1[k]} * {{CH_W{1'b0}}, d_s1[k]};
			cost_s3[k] <= cost[k];
		end
		sum_s4 <= DIST_W'(cost_s3[0]) + DIST_W'(cost_s3[1]) + DIST_W'(cost_s3[2]);
	end

	assign res.valid = v_s4;
	assign res.index = idx_s4;
	assign res.gap   = sum_s4;

endmodule

`default_nettype wire
